// File: design/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the serial line editor
// Beat payloads, result kinds, register indexes, control codes, FSM states.
// ----------------------------------------------------------------------------
package sle_pkg;

   // Default store depth and fixed field widths
   localparam int LINE_MAX_DEF = 32;
   localparam int CNT_W        = 6;
   localparam int CHAR_W       = 7;
   localparam int BYTE_W       = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;

   // Control characters
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

   // Register reset values
   localparam logic             ECHO_RST    = 1'b1;
   localparam logic [CNT_W-1:0] MAX_LEN_RST = 6'd32;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ECHO_ENABLE = 2'd0,
      CSR_MAX_LENGTH  = 2'd1
   } csr_idx_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_RD_REQ,
      ST_RD_WAIT,
      ST_END
   } state_type;

   // Backspace echo step numbers
   localparam logic [1:0] BS_STEP_SPACE = 2'd1;
   localparam logic [1:0] BS_STEP_LAST  = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      logic [CNT_W-1:0]  line_length;
      logic              last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   // Line store access enables
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: design/sle_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_chan_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface sle_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/sle_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_line_mem: line character store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sle_line_mem
   import sle_pkg::*;
#(
   parameter int DEPTH  = LINE_MAX_DEF,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] store_mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl: line editor sequencer
// Decodes received bytes, keeps the fill count and registers, drives the
// line store and the result register.
// ----------------------------------------------------------------------------
module sle_ctrl
   import sle_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEF,
   parameter int ADDR_W   = 5
) (
   input  logic              clock,
   input  logic              reset,
   sle_chan_if.sink          req_chan,
   sle_chan_if.source        rsp_chan,
   sle_chan_if.sink          csr_chan,
   output mem_ctl_type       mem_ctl,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [CHAR_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [CHAR_W-1:0] mem_rd_data
);

   localparam logic [CNT_W-1:0] LINE_MAX_C = CNT_W'(LINE_MAX);

   state_type         state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [BYTE_W-1:0] echo_byte_ff, echo_byte_in;
   logic              is_bs_ff, is_bs_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              echo_en_ff, echo_en_in;
   logic [CNT_W-1:0]  max_len_ff, max_len_in;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_data_ff, out_data_in;

   logic              accept;
   logic [BYTE_W-1:0] rx;
   logic              is_bs, is_cr, is_pr, bs_ok, pr_ok;
   logic [CNT_W-1:0]  limit;
   logic              slot_free;
   logic              echo_last;
   logic [BYTE_W-1:0] echo_cur;
   logic              csr_wr;

   // Byte decode
   assign rx        = req_chan.payload.rx_byte;
   assign accept    = req_chan.valid && req_chan.ready;
   assign limit     = (max_len_ff < LINE_MAX_C) ? max_len_ff : LINE_MAX_C;
   assign is_bs     = (rx == CH_BS);
   assign is_cr     = (rx == CH_CR);
   assign is_pr     = (rx >= CH_SP) && (rx <= CH_TILDE);
   assign bs_ok     = is_bs && (fill_ff != '0);
   assign pr_ok     = is_pr && (fill_ff < limit);
   assign slot_free = !out_valid_ff || rsp_chan.ready;

   // Current echo byte: backspace, space, backspace or the character itself
   assign echo_last = !is_bs_ff || (step_ff == BS_STEP_LAST);
   assign echo_cur  = !is_bs_ff ? echo_byte_ff :
                      (step_ff == BS_STEP_SPACE) ? CH_SP : CH_BS;

   assign csr_wr = csr_chan.valid && csr_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_cr) begin
                  state_in = ST_RD_REQ;
               end else if ((bs_ok || pr_ok) && echo_en_ff) begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_ECHO: begin
            if (slot_free && echo_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_REQ: begin
            state_in = (rd_idx_ff < len_ff) ? ST_RD_WAIT : ST_END;
         end
         ST_RD_WAIT: begin
            if (slot_free) begin
               state_in = ST_RD_REQ;
            end
         end
         ST_END: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      step_in       = step_ff;
      echo_byte_in  = echo_byte_ff;
      is_bs_in      = is_bs_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_wr_addr   = fill_ff[ADDR_W-1:0];
      mem_wr_data   = rx[CHAR_W-1:0];
      mem_rd_addr   = rd_idx_ff[ADDR_W-1:0];
      req_chan.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in      = '0;
               echo_byte_in = rx;
               is_bs_in     = is_bs;
               if (is_cr) begin
                  len_in    = fill_ff;
                  rd_idx_in = '0;
                  fill_in   = '0;
               end else if (bs_ok) begin
                  fill_in = fill_ff - 1'b1;
               end else if (pr_ok) begin
                  mem_ctl.wr_en = 1'b1;
                  fill_in       = fill_ff + 1'b1;
               end
            end
         end
         ST_ECHO: begin
            if (slot_free) begin
               out_valid_in            = 1'b1;
               out_data_in.kind        = KIND_ECHO;
               out_data_in.out_byte    = echo_cur;
               out_data_in.line_length = '0;
               out_data_in.last        = echo_last;
               step_in                 = step_ff + 1'b1;
            end
         end
         ST_RD_REQ: begin
            mem_ctl.rd_en = (rd_idx_ff < len_ff);
         end
         ST_RD_WAIT: begin
            if (slot_free) begin
               out_valid_in            = 1'b1;
               out_data_in.kind        = KIND_CHAR;
               out_data_in.out_byte    = {1'b0, mem_rd_data};
               out_data_in.line_length = '0;
               out_data_in.last        = 1'b0;
               rd_idx_in               = rd_idx_ff + 1'b1;
            end
         end
         ST_END: begin
            if (slot_free) begin
               out_valid_in            = 1'b1;
               out_data_in.kind        = KIND_END;
               out_data_in.out_byte    = '0;
               out_data_in.line_length = len_ff;
               out_data_in.last        = 1'b1;
            end
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // Register writes
   always_comb begin
      echo_en_in     = echo_en_ff;
      max_len_in     = max_len_ff;
      csr_chan.ready = 1'b1;
      if (csr_wr) begin
         case (csr_chan.payload.index)
            CSR_ECHO_ENABLE: echo_en_in = csr_chan.payload.data[0];
            CSR_MAX_LENGTH:  max_len_in = csr_chan.payload.data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
         echo_en_ff   <= ECHO_RST;
         max_len_ff   <= MAX_LEN_RST;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         echo_en_ff   <= echo_en_in;
         max_len_ff   <= max_len_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      echo_byte_ff <= echo_byte_in;
      is_bs_ff     <= is_bs_in;
      len_ff       <= len_in;
      rd_idx_ff    <= rd_idx_in;
      out_data_ff  <= out_data_in;
   end

endmodule

// File: design/serial_line_editor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_unit: terminal line editor with echo
// Edits a line from received bytes and returns echo, line and end beats.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one received byte per beat; rsp_chan returns results,
//  each with kind, out_byte, line_length and last (set on the final result
//  of a byte); csr_chan writes echo_enable (index 0) and max_length (1).
//  Printable bytes are stored and echoed once; backspace removes a character
//  and echoes backspace, space, backspace; carriage return replays the line
//  from the store, then an end beat with the length. Other bytes are dropped.
//  Sequence: a character echo is one beat, loaded from ST_ECHO after the
//  byte is accepted; a backspace echo is three beats. A line end reads
//  each character through the single store port in ST_RD_REQ, loads it
//  into the result register in ST_RD_WAIT, then sends the end beat.
//  req_chan.ready is high only between bytes; a byte that causes no result
//  leaves it high.
//  Reset clears the line, sets echo on and max_length to 32. When the
//  receiver stalls, the result register holds and the sequencer waits.
// ----------------------------------------------------------------------------
module serial_line_editor_unit
   import sle_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sle_chan_if.sink   req_chan,
   sle_chan_if.source rsp_chan,
   sle_chan_if.sink   csr_chan
);

   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   sle_ctrl #(
      .LINE_MAX (LINE_MAX),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sle_line_mem #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: design/sle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker: port-level checks of the serial line editor
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module sle_checker
   import sle_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [BYTE_W-1:0] req_rx_byte,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kind_type          rsp_kind,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last
);

   // A result beat holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // A carriage return closes the input while the line is replayed
   a_cr_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_rx_byte == CH_CR) |=> !req_ready)
      else $error("input open right after a line end");

   // End beat is the final one and carries no byte
   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |-> rsp_last && (rsp_out_byte == '0))
      else $error("malformed end of line beat");

   // Nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind serial_line_editor_unit sle_checker u_sle_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_rx_byte  (req_chan.payload.rx_byte),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.payload.kind),
   .rsp_out_byte (rsp_chan.payload.out_byte),
   .rsp_last     (rsp_chan.payload.last)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for serial_line_editor_unit
// Feeds received bytes, mostly in whole edited lines ending in carriage
// return, across several echo/max_length settings. A line editor model in
// the scoreboard predicts every echo, line and end beat, and each result
// beat is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
   import sle_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 8;

   // Line editor model plus queue of predicted result beats
   class line_editor_scoreboard;
      logic [CHAR_W-1:0] line_chars [LINE_MAX_DEF];
      int unsigned       fill;
      logic              echo_on;
      logic [CNT_W-1:0]  max_len;
      rsp_payload_type   pending_beats [$];
      int unsigned       mismatches;

      function new();
         fill        = 0;
         echo_on     = ECHO_RST;
         max_len     = MAX_LEN_RST;
         mismatches  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ECHO_ENABLE)
            echo_on = data[0];
         else if (idx == CSR_MAX_LENGTH)
            max_len = data;
      endfunction

      function void push_beat(kind_type k, logic [BYTE_W-1:0] b, logic [CNT_W-1:0] len,
                              logic is_last);
         rsp_payload_type beat;
         beat.kind        = k;
         beat.out_byte    = b;
         beat.line_length = len;
         beat.last        = is_last;
         pending_beats.push_back(beat);
      endfunction

      function int unsigned line_cap();
         return (max_len < LINE_MAX_DEF) ? max_len : LINE_MAX_DEF;
      endfunction

      // Edit the line with one received byte and predict its results
      function void note_byte(logic [BYTE_W-1:0] b);
         if (b == CH_BS) begin
            if (fill > 0) begin
               fill--;
               if (echo_on) begin
                  push_beat(KIND_ECHO, CH_BS, '0, 1'b0);
                  push_beat(KIND_ECHO, CH_SP, '0, 1'b0);
                  push_beat(KIND_ECHO, CH_BS, '0, 1'b1);
               end
            end
         end else if (b == CH_CR) begin
            for (int i = 0; i < fill; i++)
               push_beat(KIND_CHAR, {1'b0, line_chars[i]}, '0, 1'b0);
            push_beat(KIND_END, '0, CNT_W'(fill), 1'b1);
            fill = 0;
         end else if (b >= CH_SP && b <= CH_TILDE) begin
            // full line drops the byte silently
            if (fill < line_cap()) begin
               line_chars[fill] = b[CHAR_W-1:0];
               fill++;
               if (echo_on)
                  push_beat(KIND_ECHO, b, '0, 1'b1);
            end
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d out_byte %0h line_length %0d last %0b",
                   got.kind, got.out_byte, got.line_length, got.last);
            mismatches++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.out_byte != want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.line_length != want.line_length) begin
            $error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
            mismatches++;
         end
         if (got.last != want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return pending_beats.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   bit   stall_on;

   line_editor_scoreboard sb;

   sle_chan_if #(.payload_type(req_payload_type)) req_if ();
   sle_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   sle_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   serial_line_editor_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run-away guard
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Beat monitor: sample all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.write_register(csr_if.payload.index, csr_if.payload.data);
         if (req_if.valid && req_if.ready)
            sb.note_byte(req_if.payload.rx_byte);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.payload);
      end
   end

   // Result receiver: ready held, or dropped at random in bursts while stall_on is set
   initial begin
      rsp_if.ready = 1'b1;
      forever begin
         rsp_if.ready = !(stall_on && $urandom_range(0, 2) == 0);
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // Send one byte; entered and left at a falling edge, valid left high
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_if.valid           = 1'b1;
      req_if.payload.rx_byte = b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid         = 1'b1;
      csr_if.payload.index = idx;
      csr_if.payload.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   // Wait for all predicted beats, then let a dropped byte finish
   task automatic drain();
      req_if.valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic echo, input logic [CSR_DATA_W-1:0] max_len);
      drain();
      write_csr(CSR_ECHO_ENABLE, {{(CSR_DATA_W-1){1'b0}}, echo});
      write_csr(CSR_MAX_LENGTH, max_len);
      csr_if.valid = 1'b0;
   endtask

   // Random lines: most hover near empty, some run past the length cap
   task automatic send_lines(input int budget, input bit gaps);
      int sent;
      int line_len;
      int pick;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 3) == 0)
            line_len = sb.line_cap() + $urandom_range(0, 3);
         else
            line_len = $urandom_range(0, 6);
         for (int j = 0; j < line_len; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_byte(CH_BS, gaps);
               sent++;
            end else if (pick < 16) begin
               // noise: anything at all, bit 7 included
               send_byte(BYTE_W'($urandom_range(0, 255)), gaps);
            end else begin
               send_byte(BYTE_W'($urandom_range(CH_SP, CH_TILDE)), gaps);
               sent++;
            end
         end
         send_byte(CH_CR, gaps);
         sent++;
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] directed_bytes [$];
      logic              phase_echo [8];
      logic [CNT_W-1:0]  phase_max [8];

      sb                     = new();
      stall_on               = 1'b1;
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.payload.rx_byte = '0;
      csr_if.valid           = 1'b0;
      csr_if.payload.index   = CSR_ECHO_ENABLE;
      csr_if.payload.data    = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: empty line end, backspace on empty, printable edges,
      // erasure, line end, ignored control and high bytes
      directed_bytes = '{CH_CR, CH_BS, CH_SP, CH_TILDE, 8'h41, CH_BS, CH_CR,
                         8'h00, 8'hFF, 8'h7F, 8'h1F, 8'h80, 8'h0A, CH_CR};
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i], 1'b0);

      // Zero length cap drops everything printable
      set_config(1'b1, 6'd0);
      send_byte(8'h78, 1'b0);
      send_byte(CH_CR, 1'b0);

      // Cap of two: third byte dropped on a full line
      set_config(1'b1, 6'd2);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(CH_CR, 1'b0);

      // Echo off: only the line and end beats come out
      set_config(1'b0, 6'd63);
      send_byte(8'h71, 1'b0);
      send_byte(CH_BS, 1'b0);
      send_byte(8'h72, 1'b0);
      send_byte(CH_CR, 1'b0);

      // Random phases over a spread of settings; last phase runs flat out
      phase_echo = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      phase_max  = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd5, 6'd31,
                     CNT_W'($urandom_range(0, 63)), 6'd17};
      for (int p = 0; p < 8; p++) begin
         set_config(phase_echo[p], phase_max[p]);
         if (p == 7)
            stall_on = 1'b0;
         send_lines(57, p != 7);
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
